[design/urd_pkg.sv]
// Shared types and the single-bit restoring step for the unsigned divider.
// No dependencies; imported by urd_pipe and unsigned_restoring_divider_top.
package urd_pkg;

	localparam int URD_WIDTH = 32;

	typedef struct packed {
		logic [URD_WIDTH-1:0] rem;  // partial remainder
		logic [URD_WIDTH-1:0] nq;   // dividend bits still to go, quotient bits shift in below
		logic [URD_WIDTH-1:0] den;  // divisor
		logic                 dbz;  // divisor was zero
	} urd_data_t;

	// One restoring step: shift the next dividend bit into the remainder and
	// subtract the divisor when it fits. Since rem < den on entry, the shifted
	// value is below 2*den, so one borrow bit decides the compare.
	function automatic urd_data_t urd_step(urd_data_t d);
		logic [URD_WIDTH:0] hi;
		logic [URD_WIDTH:0] diff;
		urd_data_t          r;
		r    = d;
		hi   = {d.rem, d.nq[URD_WIDTH-1]};
		diff = hi - {1'b0, d.den};
		if (!diff[URD_WIDTH]) begin
			r.rem = diff[URD_WIDTH-1:0];
			r.nq  = {d.nq[URD_WIDTH-2:0], 1'b1};
		end else begin
			r.rem = hi[URD_WIDTH-1:0];
			r.nq  = {d.nq[URD_WIDTH-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

[design/urd_pipe.sv]
// Divider array: one restoring step per pipeline stage, URD_WIDTH stages.
// Depends on urd_pkg (urd_data_t, urd_step).
module urd_pipe import urd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_vld,
	input  urd_data_t in_data,
	output logic      out_vld,
	output urd_data_t out_data
);

	// stage k holds the item after k steps
	logic [URD_WIDTH:1] vld_s;
	urd_data_t          data_s [1:URD_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[URD_WIDTH-1:1], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s[1] <= urd_step(in_data);
		end
	end

	for (genvar k = 2; k <= URD_WIDTH; k++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				data_s[k] <= urd_step(data_s[k-1]);
			end
		end
	end

	assign out_vld  = vld_s[URD_WIDTH];
	assign out_data = data_s[URD_WIDTH];

	// a stalled array keeps every item in place
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("urd_pipe: valid bits moved during stall");

	// an item entering shows up in stage one
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		en && in_vld |=> vld_s[1])
		else $error("urd_pipe: transfer lost at entry");

endmodule

[design/unsigned_restoring_divider_top.sv]
// Unsigned radix-2 restoring divider, 32-bit operands, quotient and remainder.
// Path: an input transfer loads the first of 32 restoring step stages; the last
// stage feeds the output reg.
// Throughput: one division per cycle while in_ready; one step per stage sets the depth.
// Output register plus one skid entry: input closes only once a second result
// queues behind a waiting one.
// Reset (arst_n, async, active low) clears all valid bits; data regs are not reset.
// Depends on urd_pkg and urd_pipe.
module unsigned_restoring_divider_top import urd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [URD_WIDTH-1:0] dividend,
	input  logic [URD_WIDTH-1:0] divisor,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [URD_WIDTH-1:0] quotient,
	output logic [URD_WIDTH-1:0] remainder,
	output logic                 divide_by_zero
);

	logic      en;
	logic      p_vld;
	urd_data_t in_data;
	urd_data_t p_data;
	urd_data_t skid_q;
	logic      skid_vld_q;
	logic      out_vld_q;
	logic      take;
	logic      arrive;

	assign en       = !skid_vld_q;
	assign in_ready = en;

	always_comb begin
		in_data.rem = '0;
		in_data.nq  = dividend;
		in_data.den = divisor;
		in_data.dbz = (divisor == '0);
	end

	urd_pipe u_pipe (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.in_data (in_data),
		.out_vld (p_vld),
		.out_data(p_data)
	);

	assign take   = out_vld_q && out_ready;
	assign arrive = p_vld && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || take) begin
			out_vld_q  <= skid_vld_q || arrive;
			skid_vld_q <= 1'b0;
		end else if (arrive) begin
			skid_vld_q <= 1'b1;
		end
	end

	// payload: zero divisor forces quotient and remainder to zero on load
	always_ff @(posedge clk) begin
		if (!out_vld_q || take) begin
			if (skid_vld_q) begin
				quotient       <= skid_q.dbz ? '0 : skid_q.nq;
				remainder      <= skid_q.dbz ? '0 : skid_q.rem;
				divide_by_zero <= skid_q.dbz;
			end else begin
				quotient       <= p_data.dbz ? '0 : p_data.nq;
				remainder      <= p_data.dbz ? '0 : p_data.rem;
				divide_by_zero <= p_data.dbz;
			end
		end
		if (out_vld_q && !out_ready && arrive) begin
			skid_q <= p_data;
		end
	end

	assign out_valid = out_vld_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("divider: skid entry held with empty output register");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !out_ready))
		else $error("divider: skid filled without output stall");

	a_dbz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> quotient == '0 && remainder == '0)
		else $error("divider: zero divisor result not cleared");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && out_ready |=> out_vld_q && !skid_vld_q)
		else $error("divider: skid entry not moved on output transfer");

endmodule
